FILE: hw/rtl/calendar_date_to_epoch_assert.svh
// assertion macros for the date to epoch converter
`ifndef CALENDAR_DATE_TO_EPOCH_ASSERT_SVH
`define CALENDAR_DATE_TO_EPOCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CDE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define CDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`define CDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/cde_pkg.sv
package cde_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int FIELD6_W = 6;
    localparam int TZ_W     = 11;
    localparam int YOFF_W   = 13;
    localparam int YDAY_W   = 9;
    localparam int WDAY_W   = 3;
    localparam int EPOCH_W  = 39;
    localparam int DAYS_W   = 23;
    localparam int HM_W     = 28;
    localparam int MINS_W   = 35;
    localparam int ADJ_W    = 13;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;

    localparam int PIPE_DEPTH = 7;

    localparam logic [YEAR_W-1:0] YEAR_BASE   = 14'd1900;
    localparam logic [YEAR_W-1:0] LEAP_PIVOT  = 14'd1970;
    localparam logic [YEAR_W-1:0] EPOCH_OFF   = 14'd70;
    localparam logic [YEAR_W-1:0] CENT_1701   = 14'd1701;
    localparam logic [YEAR_W-1:0] CENT_1601   = 14'd1601;
    localparam logic [DAYS_W-1:0] LEAPS_1969  = 23'd477;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TZ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST = 2'd1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DAY    = 3'd1,
        ST_BAD_MONTH  = 3'd2,
        ST_BAD_HOUR   = 3'd3,
        ST_BAD_MINUTE = 3'd4,
        ST_BAD_SECOND = 3'd5
    } cde_status_t;

    typedef struct packed {
        logic [TZ_W-1:0] tz_minutes_west;
        logic            dst_active;
    } cde_cfg_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year_in;
        logic [MONTH_W-1:0]  month_in;
        logic [FIELD6_W-1:0] day_in;
        logic [FIELD6_W-1:0] hour_in;
        logic [FIELD6_W-1:0] minute_in;
        logic [FIELD6_W-1:0] second_in;
    } cde_in_t;

    typedef struct packed {
        cde_status_t        status;
        logic [YOFF_W-1:0]  year_offset;
        logic [YDAY_W-1:0]  day_of_year;
        logic [WDAY_W-1:0]  day_of_week;
        logic [EPOCH_W-1:0] epoch_seconds;
    } cde_out_t;

    // floor(v / 25) by reciprocal, exact for v below 43690
    function automatic logic [10:0] div25_q(input logic [14:0] v);
        logic [30:0] prod;
        prod = {16'd0, v} * 31'd41944;
        return prod[30:20];
    endfunction

    // floor(v / 7) by reciprocal, exact for v below 43690
    function automatic logic [12:0] div7_q(input logic [14:0] v);
        logic [30:0] prod;
        prod = {16'd0, v} * 31'd37450;
        return prod[30:18];
    endfunction

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] r;
        case (m)
            4'd0:    r = 5'd31;
            4'd1:    r = 5'd28;
            4'd2:    r = 5'd31;
            4'd3:    r = 5'd30;
            4'd4:    r = 5'd31;
            4'd5:    r = 5'd30;
            4'd6:    r = 5'd31;
            4'd7:    r = 5'd31;
            4'd8:    r = 5'd30;
            4'd9:    r = 5'd31;
            4'd10:   r = 5'd30;
            4'd11:   r = 5'd31;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    // days before the first of each month, common year
    function automatic logic [YDAY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/calendar_date_to_epoch.sv
// calendar date to epoch converter
// s_axis carries one broken-down date per word; m_axis returns one result word
// per input word, in order: status, year offset, day of year, day of week and
// seconds since 1970 with the time zone and daylight saving registers applied.
// cfg_* writes a register: index 0 tz_minutes_west (11 bit signed), index 1
// dst_active (bit 0); write only while no word is in flight. cfg_ready is
// always high.
// a new word can be taken every cycle unless the output stalls, so
// throughput is one word per clock, set by the seven register stages.
// when m_axis_tready is low the pipeline fills behind the output register and
// s_axis_tready drops once all seven stages hold a word; nothing is lost.
// rst_n clears the pipeline valids and both registers to zero; the block
// can take a word as soon as reset is released.
module calendar_date_to_epoch
    import cde_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // year_in[13:0], month_in[17:14], day_in[23:18], hour_in[29:24],
    // minute_in[35:30], second_in[41:36], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[2:0], year_offset[15:3], day_of_year[24:16], day_of_week[27:25],
    // epoch_seconds[66:28], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TZ_W-1:0]        cfg_data
);

    cde_cfg_t cfg;
    cde_in_t  in_item;
    cde_out_t out_item;

    assign in_item.year_in   = s_axis_tdata[13:0];
    assign in_item.month_in  = s_axis_tdata[17:14];
    assign in_item.day_in    = s_axis_tdata[23:18];
    assign in_item.hour_in   = s_axis_tdata[29:24];
    assign in_item.minute_in = s_axis_tdata[35:30];
    assign in_item.second_in = s_axis_tdata[41:36];

    assign m_axis_tdata = {5'd0, out_item.epoch_seconds, out_item.day_of_week,
                           out_item.day_of_year, out_item.year_offset,
                           out_item.status};

    cde_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cde_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item),
        .cfg       (cfg)
    );

endmodule

FILE: hw/rtl/cde_cfg_regs.sv
module cde_cfg_regs
    import cde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TZ_W-1:0]      cfg_data,
    output cde_cfg_t             cfg
);

    logic [TZ_W-1:0] tz_reg, tz_next;
    logic            dst_reg, dst_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tz_next  = tz_reg;
        dst_next = dst_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TZ:  tz_next  = cfg_data;
                REG_DST: dst_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg  <= '0;
            dst_reg <= 1'b0;
        end
        else
        begin
            tz_reg  <= tz_next;
            dst_reg <= dst_next;
        end
    end

    assign cfg.tz_minutes_west = tz_reg;
    assign cfg.dst_active      = dst_reg;

endmodule

FILE: hw/rtl/cde_datapath.sv
`include "calendar_date_to_epoch_assert.svh"

module cde_datapath
    import cde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cde_in_t  in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output cde_out_t out_item,
    input  cde_cfg_t cfg
);

    localparam int LAST = PIPE_DEPTH - 1;

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next, en;

    // stage 1: year offset and leap test values
    logic [YEAR_W-1:0]   s1_off_reg, s1_off_next;
    logic [YEAR_W-1:0]   s1_lvr_reg, s1_lvr_next;
    logic [YEAR_W-1:0]   s1_lvo_reg, s1_lvo_next;
    logic [YEAR_W-1:0]   s1_y_reg, s1_y_next;
    logic [MONTH_W-1:0]  s1_mon_reg;
    logic [FIELD6_W-1:0] s1_day_reg, s1_hour_reg, s1_min_reg, s1_sec_reg;

    // stage 2: quotients by 25
    logic [10:0]         s2_qr_reg, s2_qr_next;
    logic [10:0]         s2_qo_reg, s2_qo_next;
    logic [10:0]         s2_qa_reg, s2_qa_next;
    logic [10:0]         s2_qb_reg, s2_qb_next;
    logic [10:0]         s2_qc_reg, s2_qc_next;
    logic [10:0]         s2_qd_reg, s2_qd_next;
    logic [YEAR_W-1:0]   s2_off_reg, s2_lvr_reg, s2_lvo_reg, s2_y_reg;
    logic [MONTH_W-1:0]  s2_mon_reg;
    logic [FIELD6_W-1:0] s2_day_reg, s2_hour_reg, s2_min_reg, s2_sec_reg;

    // stage 3: checks, day of year, weekday sum, day base
    cde_status_t         s3_status_reg, s3_status_next;
    logic [YDAY_W-1:0]   s3_yday_reg, s3_yday_next;
    logic [14:0]         s3_d_reg, s3_d_next;
    logic [DAYS_W-1:0]   s3_base_reg, s3_base_next;
    logic [YEAR_W-1:0]   s3_off_reg;
    logic [FIELD6_W-1:0] s3_hour_reg, s3_min_reg, s3_sec_reg;

    // stage 4: days since 1970, weekday quotient
    logic [DAYS_W-1:0]   s4_days_reg, s4_days_next;
    logic [12:0]         s4_q7_reg, s4_q7_next;
    cde_status_t         s4_status_reg;
    logic [YDAY_W-1:0]   s4_yday_reg;
    logic [14:0]         s4_d_reg;
    logic [YEAR_W-1:0]   s4_off_reg;
    logic [FIELD6_W-1:0] s4_hour_reg, s4_min_reg, s4_sec_reg;

    // stage 5: hours, jan 1 weekday, minute adjust
    logic [HM_W-1:0]     s5_hm_reg, s5_hm_next;
    logic [WDAY_W-1:0]   s5_jan1_reg, s5_jan1_next;
    logic [ADJ_W-1:0]    s5_adj_reg, s5_adj_next;
    cde_status_t         s5_status_reg;
    logic [YDAY_W-1:0]   s5_yday_reg;
    logic [YEAR_W-1:0]   s5_off_reg;
    logic [FIELD6_W-1:0] s5_sec_reg;

    // stage 6: minutes, weekday sum and quotient
    logic [MINS_W-1:0]   s6_mins_reg, s6_mins_next;
    logic [YDAY_W-1:0]   s6_sw_reg, s6_sw_next;
    logic [12:0]         s6_qsw_reg, s6_qsw_next;
    cde_status_t         s6_status_reg;
    logic [YDAY_W-1:0]   s6_yday_reg;
    logic [YEAR_W-1:0]   s6_off_reg;
    logic [FIELD6_W-1:0] s6_sec_reg;

    // stage 7: output word
    cde_out_t            s7_out_reg, s7_out_next;

    // flow control: a stage loads when it is empty or its word moves on
    always_comb
    begin
        en[LAST] = !vld_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[LAST];
    assign out_item  = s7_out_reg;

    // ---------------- stage 1
    always_comb
    begin
        s1_off_next = (in_item.year_in >= YEAR_BASE) ? in_item.year_in - YEAR_BASE
                                                     : in_item.year_in;
        s1_lvr_next = (in_item.year_in < LEAP_PIVOT) ? in_item.year_in + YEAR_BASE
                                                     : in_item.year_in;
        s1_lvo_next = (s1_off_next < LEAP_PIVOT) ? s1_off_next + YEAR_BASE : s1_off_next;
        s1_y_next   = s1_off_next + YEAR_BASE;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_off_reg  <= s1_off_next;
            s1_lvr_reg  <= s1_lvr_next;
            s1_lvo_reg  <= s1_lvo_next;
            s1_y_reg    <= s1_y_next;
            s1_mon_reg  <= in_item.month_in;
            s1_day_reg  <= in_item.day_in;
            s1_hour_reg <= in_item.hour_in;
            s1_min_reg  <= in_item.minute_in;
            s1_sec_reg  <= in_item.second_in;
        end
    end

    // ---------------- stage 2
    always_comb
    begin
        logic [YEAR_W-1:0] ya, yb, yc;
        ya = s1_y_reg - CENT_1701;
        yb = s1_y_reg - CENT_1601;
        yc = s1_y_reg - 14'd1;
        s2_qr_next = div25_q({1'b0, s1_lvr_reg});
        s2_qo_next = div25_q({1'b0, s1_lvo_reg});
        // x/100 = (x/4)/25, x/400 = (x/16)/25
        s2_qa_next = div25_q({3'd0, ya[13:2]});
        s2_qb_next = div25_q({5'd0, yb[13:4]});
        s2_qc_next = div25_q({3'd0, yc[13:2]});
        s2_qd_next = div25_q({5'd0, yc[13:4]});
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_qr_reg   <= s2_qr_next;
            s2_qo_reg   <= s2_qo_next;
            s2_qa_reg   <= s2_qa_next;
            s2_qb_reg   <= s2_qb_next;
            s2_qc_reg   <= s2_qc_next;
            s2_qd_reg   <= s2_qd_next;
            s2_off_reg  <= s1_off_reg;
            s2_lvr_reg  <= s1_lvr_reg;
            s2_lvo_reg  <= s1_lvo_reg;
            s2_y_reg    <= s1_y_reg;
            s2_mon_reg  <= s1_mon_reg;
            s2_day_reg  <= s1_day_reg;
            s2_hour_reg <= s1_hour_reg;
            s2_min_reg  <= s1_min_reg;
            s2_sec_reg  <= s1_sec_reg;
        end
    end

    // ---------------- stage 3
    always_comb
    begin
        logic              leap_raw, leap_off;
        logic [YEAR_W-1:0] yc;
        logic [14:0]       yq;
        logic [YEAR_W-1:0] offm;
        // leap: divisible by 4 and (not by 25, or by 16)
        leap_raw = (s2_lvr_reg[1:0] == 2'd0)
                && ((s2_lvr_reg != 14'({3'd0, s2_qr_reg} * 14'd25))
                    || (s2_lvr_reg[3:0] == 4'd0));
        leap_off = (s2_lvo_reg[1:0] == 2'd0)
                && ((s2_lvo_reg != 14'({3'd0, s2_qo_reg} * 14'd25))
                    || (s2_lvo_reg[3:0] == 4'd0));

        if (s2_day_reg == '0)
            s3_status_next = ST_BAD_DAY;
        else if (s2_mon_reg > 4'd11)
            s3_status_next = ST_BAD_MONTH;
        else if ((s2_day_reg > {1'b0, month_len(s2_mon_reg)})
                 && !((s2_mon_reg == 4'd1) && (s2_day_reg == 6'd29) && leap_raw))
            s3_status_next = ST_BAD_DAY;
        else if (s2_hour_reg > 6'd23)
            s3_status_next = ST_BAD_HOUR;
        else if (s2_min_reg > 6'd59)
            s3_status_next = ST_BAD_MINUTE;
        else if (s2_sec_reg > 6'd59)
            s3_status_next = ST_BAD_SECOND;
        else
            s3_status_next = ST_OK;

        s3_yday_next = cum_days(s2_mon_reg)
                     + {8'd0, (leap_off && (s2_mon_reg > 4'd1))}
                     + {3'd0, s2_day_reg} - 9'd1;

        // jan 1 weekday before mod 7, with the 1752 shift of three days
        yq = ({1'b0, s2_y_reg} + 15'd3) >> 2;
        s3_d_next = 15'd7 + {1'b0, s2_y_reg} + yq
                  - {4'd0, s2_qa_reg} + {4'd0, s2_qb_reg};

        yc   = s2_y_reg - 14'd1;
        offm = s2_off_reg - EPOCH_OFF;
        s3_base_next = 23'({9'd0, offm} * 23'd365) + {11'd0, yc[13:2]}
                     - {12'd0, s2_qc_reg} + {12'd0, s2_qd_reg} - LEAPS_1969;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_status_reg <= s3_status_next;
            s3_yday_reg   <= s3_yday_next;
            s3_d_reg      <= s3_d_next;
            s3_base_reg   <= s3_base_next;
            s3_off_reg    <= s2_off_reg;
            s3_hour_reg   <= s2_hour_reg;
            s3_min_reg    <= s2_min_reg;
            s3_sec_reg    <= s2_sec_reg;
        end
    end

    // ---------------- stage 4
    always_comb
    begin
        s4_days_next = s3_base_reg + {14'd0, s3_yday_reg};
        s4_q7_next   = div7_q(s3_d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_days_reg   <= s4_days_next;
            s4_q7_reg     <= s4_q7_next;
            s4_status_reg <= s3_status_reg;
            s4_yday_reg   <= s3_yday_reg;
            s4_d_reg      <= s3_d_reg;
            s4_off_reg    <= s3_off_reg;
            s4_hour_reg   <= s3_hour_reg;
            s4_min_reg    <= s3_min_reg;
            s4_sec_reg    <= s3_sec_reg;
        end
    end

    // ---------------- stage 5
    always_comb
    begin
        logic [14:0] d_r;
        s5_hm_next   = {5'd0, s4_days_reg} * 28'd24 + {22'd0, s4_hour_reg};
        d_r          = s4_d_reg - 15'({2'd0, s4_q7_reg} * 15'd7);
        s5_jan1_next = d_r[2:0];
        s5_adj_next  = {7'd0, s4_min_reg}
                     + {{(ADJ_W-TZ_W){cfg.tz_minutes_west[TZ_W-1]}}, cfg.tz_minutes_west}
                     - (cfg.dst_active ? 13'd60 : 13'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_hm_reg     <= s5_hm_next;
            s5_jan1_reg   <= s5_jan1_next;
            s5_adj_reg    <= s5_adj_next;
            s5_status_reg <= s4_status_reg;
            s5_yday_reg   <= s4_yday_reg;
            s5_off_reg    <= s4_off_reg;
            s5_sec_reg    <= s4_sec_reg;
        end
    end

    // ---------------- stage 6
    always_comb
    begin
        s6_mins_next = {7'd0, s5_hm_reg} * 35'd60
                     + {{(MINS_W-ADJ_W){s5_adj_reg[ADJ_W-1]}}, s5_adj_reg};
        s6_sw_next   = {6'd0, s5_jan1_reg} + s5_yday_reg;
        s6_qsw_next  = div7_q({6'd0, s6_sw_next});
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_mins_reg   <= s6_mins_next;
            s6_sw_reg     <= s6_sw_next;
            s6_qsw_reg    <= s6_qsw_next;
            s6_status_reg <= s5_status_reg;
            s6_yday_reg   <= s5_yday_reg;
            s6_off_reg    <= s5_off_reg;
            s6_sec_reg    <= s5_sec_reg;
        end
    end

    // ---------------- stage 7, output register
    always_comb
    begin
        logic [EPOCH_W-1:0] epoch;
        logic [YDAY_W-1:0]  w_r;
        epoch = {{(EPOCH_W-MINS_W){s6_mins_reg[MINS_W-1]}}, s6_mins_reg} * 39'd60
              + {33'd0, s6_sec_reg};
        w_r   = s6_sw_reg - 9'({s6_qsw_reg[8:0]} * 9'd7);

        s7_out_next = '0;
        s7_out_next.status = s6_status_reg;
        if (s6_status_reg == ST_OK)
        begin
            s7_out_next.year_offset = s6_off_reg[YOFF_W-1:0];
            s7_out_next.day_of_year = s6_yday_reg;
            s7_out_next.day_of_week = w_r[2:0];
            if (s6_off_reg >= EPOCH_OFF)
            begin
                s7_out_next.epoch_seconds = epoch;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_out_reg <= s7_out_next;
        end
    end

    `CDE_ASSERT_IMPLY(a_err_zero, clk, rst_n,
        out_valid && (out_item.status != ST_OK),
        (out_item.year_offset == '0) && (out_item.day_of_year == '0)
        && (out_item.day_of_week == '0) && (out_item.epoch_seconds == '0),
        "error word carries nonzero payload")

    `CDE_ASSERT_IMPLY(a_pre_epoch_zero, clk, rst_n,
        out_valid && (out_item.year_offset < 13'd70),
        out_item.epoch_seconds == '0,
        "epoch nonzero for year offset below 70")

    `CDE_ASSERT_IMPLY(a_ok_ranges, clk, rst_n,
        out_valid && (out_item.status == ST_OK),
        (out_item.day_of_week < 3'd7) && (out_item.day_of_year < 9'd366),
        "weekday or day of year out of range")

    `CDE_ASSERT_IMPLY(a_full_stall, clk, rst_n,
        (&vld_reg) && !out_ready,
        !in_ready,
        "input taken while pipeline full and stalled")

    `CDE_ASSERT_NEXT(a_last_load, clk, rst_n,
        vld_reg[LAST-1] && en[LAST],
        out_valid,
        "word lost entering output register")

endmodule

FILE: tb/calendar_date_to_epoch_tb.sv
`timescale 1ns / 100ps

module calendar_date_to_epoch_tb;
    import cde_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 136;
    localparam int PHASE_COUNT  = 7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TZ_W-1:0]        cfg_data = '0;

    // local copy of the block's registers
    logic signed [TZ_W-1:0] tz_setting = '0;
    logic                   dst_setting = 1'b0;

    cde_in_t  pending_dates[$];
    cde_out_t awaited_conversions[$];
    cde_in_t  date_on_bus = '0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int fail_count = 0;
    int stall_cycles = 0;

    calendar_date_to_epoch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int month_days(input int m);
        case (m)
            1:           return 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    // values below 1970 are taken as offsets from 1900
    function automatic bit leap_year(input longint unsigned v);
        if (v < 1970)
            v += 1900;
        return (v % 4 == 0) && ((v % 100 != 0) || (v % 400 == 0));
    endfunction

    function automatic longint leap_count(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // weekday of january 1, with the 1752 calendar switch
    function automatic longint jan1_dow(input longint y);
        longint d;
        d = 4 + y + (y + 3) / 4;
        if (y > 1800)
        begin
            d -= (y - 1701) / 100;
            d += (y - 1601) / 400;
        end
        if (y > 1752)
            d += 3;
        return d % 7;
    endfunction

    function automatic cde_out_t convert_date(input cde_in_t d,
                                              input logic signed [TZ_W-1:0] tz,
                                              input logic dst);
        cde_out_t r;
        longint unsigned off;
        longint yday, y, days, ep, tzl, hr, mn, sc;
        longint wday;
        int i;
        r = '0;
        r.status = ST_OK;
        if (d.day_in == 0)
            r.status = ST_BAD_DAY;
        else if (d.month_in > 11)
            r.status = ST_BAD_MONTH;
        else if (d.day_in > month_days(int'(d.month_in)) &&
                 !(d.month_in == 1 && d.day_in == 29 && leap_year(64'(d.year_in))))
            r.status = ST_BAD_DAY;
        else if (d.hour_in > 23)
            r.status = ST_BAD_HOUR;
        else if (d.minute_in > 59)
            r.status = ST_BAD_MINUTE;
        else if (d.second_in > 59)
            r.status = ST_BAD_SECOND;
        if (r.status != ST_OK)
            return r;

        off = 64'(d.year_in);
        if (off >= 1900)
            off -= 1900;
        yday = (d.month_in > 1 && leap_year(off)) ? 1 : 0;
        for (i = 0; i < d.month_in; i++)
            yday += longint'(month_days(i));
        yday += longint'(d.day_in) - 1;
        y = longint'(off) + 1900;
        wday = (jan1_dow(y) + yday) % 7;

        ep = 0;
        if (off >= 70)
        begin
            tzl = longint'(tz);
            hr = longint'(d.hour_in);
            mn = longint'(d.minute_in);
            sc = longint'(d.second_in);
            days = 365 * (y - 1970) + leap_count(y - 1) - leap_count(1969) + yday;
            ep = days * 24 + hr;
            ep = ep * 60 + mn + tzl - (dst ? 60 : 0);
            ep = ep * 60 + sc;
        end
        r.year_offset = off[YOFF_W-1:0];
        r.day_of_year = yday[YDAY_W-1:0];
        r.day_of_week = wday[WDAY_W-1:0];
        r.epoch_seconds = ep[EPOCH_W-1:0];
        return r;
    endfunction

    // sender: words come from pending_dates, prediction made on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        cde_in_t next_date;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_conversions.push_back(convert_date(date_on_bus, tz_setting,
                                                           dst_setting));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_dates.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    next_date = pending_dates.pop_front();
                    date_on_bus <= next_date;
                    s_axis_tdata <= {6'd0, next_date.second_in, next_date.minute_in,
                                     next_date.hour_in, next_date.day_in,
                                     next_date.month_in, next_date.year_in};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cde_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_conversions.size() == 0)
            begin
                $error("result word with nothing pending: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = awaited_conversions.pop_front();
                check_field("status", 64'(want.status), 64'(m_axis_tdata[2:0]));
                check_field("year_offset", 64'(want.year_offset),
                            64'(m_axis_tdata[15:3]));
                check_field("day_of_year", 64'(want.day_of_year),
                            64'(m_axis_tdata[24:16]));
                check_field("day_of_week", 64'(want.day_of_week),
                            64'(m_axis_tdata[27:25]));
                check_field("epoch_seconds", 64'(want.epoch_seconds),
                            64'(m_axis_tdata[66:28]));
                check_field("tdata fill", 64'(0), 64'(m_axis_tdata[OUT_TDATA_W-1:67]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TZ_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TZ)
            tz_setting = value;
        else if (idx == REG_DST)
            dst_setting = value[0];
    endtask

    task automatic push_date(input int y, input int m, input int d,
                             input int h, input int mi, input int s);
        cde_in_t date;
        date.year_in = YEAR_W'(y);
        date.month_in = MONTH_W'(m);
        date.day_in = FIELD6_W'(d);
        date.hour_in = FIELD6_W'(h);
        date.minute_in = FIELD6_W'(mi);
        date.second_in = FIELD6_W'(s);
        pending_dates.push_back(date);
    endtask

    // waits until the sender is idle and the pipeline has emptied
    task automatic wait_drained();
        while (pending_dates.size() != 0 || s_axis_tvalid ||
               awaited_conversions.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    initial
    begin
        cde_in_t date;
        int p, n, r, len, tz_value, dst_value;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct = 22;
        snk_idle_pct = 45;

        // directed dates, reset register values
        push_date(1970, 0, 1, 0, 0, 0);
        push_date(9999, 11, 31, 23, 59, 59);
        push_date(0, 0, 1, 0, 0, 0);
        push_date(69, 11, 31, 23, 59, 59);
        push_date(70, 0, 1, 0, 0, 0);
        push_date(1900, 0, 1, 0, 0, 0);
        push_date(1969, 11, 31, 23, 59, 59);
        push_date(2038, 0, 19, 3, 14, 8);
        push_date(1752, 8, 14, 12, 0, 0);
        push_date(1753, 0, 1, 0, 0, 0);
        push_date(100, 2, 1, 0, 0, 0);
        push_date(2000, 1, 29, 0, 0, 0);
        push_date(1900, 1, 29, 0, 0, 0);
        push_date(1700, 1, 29, 0, 0, 0);
        push_date(2100, 1, 29, 12, 0, 0);
        push_date(2000, 1, 30, 0, 0, 0);
        push_date(2001, 3, 31, 0, 0, 0);
        push_date(2001, 0, 32, 0, 0, 0);
        push_date(2001, 0, 0, 0, 0, 0);
        push_date(2001, 12, 1, 0, 0, 0);
        push_date(2001, 15, 0, 0, 0, 0);
        push_date(2001, 5, 15, 24, 0, 0);
        push_date(2001, 5, 15, 23, 60, 0);
        push_date(2001, 5, 15, 23, 59, 60);
        push_date(2001, 5, 15, 63, 63, 63);
        wait_drained();

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       begin tz_value = -720; dst_value = 0; end
                1:       begin tz_value = 720;  dst_value = 1; end
                2:       begin tz_value = 0;    dst_value = 1; end
                4:       begin tz_value = -720; dst_value = 1; end
                5:       begin tz_value = 720;  dst_value = 0; end
                default:
                begin
                    tz_value = int'($urandom_range(0, 1440)) - 720;
                    dst_value = int'($urandom_range(0, 1));
                end
            endcase
            if (p < 2)
            begin
                src_idle_pct = 22;
                snk_idle_pct = 45;
            end
            else if (p < 4)
            begin
                src_idle_pct = 45;
                snk_idle_pct = 22;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_register(REG_TZ, TZ_W'(tz_value));
            write_register(REG_DST, TZ_W'(dst_value));
            @(negedge clk);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       date.year_in = YEAR_W'($urandom_range(0, 99));
                    1:       date.year_in = YEAR_W'($urandom_range(100, 1899));
                    2:       date.year_in = YEAR_W'($urandom_range(1900, 1969));
                    3, 4, 5: date.year_in = YEAR_W'($urandom_range(1970, 2100));
                    6, 7:    date.year_in = YEAR_W'($urandom_range(2101, 9999));
                    8:
                    begin
                        case ($urandom_range(0, 7))
                            0:       date.year_in = 1700;
                            1:       date.year_in = 1752;
                            2:       date.year_in = 1900;
                            3:       date.year_in = 2000;
                            4:       date.year_in = 1969;
                            5:       date.year_in = 70;
                            6:       date.year_in = 9999;
                            default: date.year_in = 0;
                        endcase
                    end
                    default: date.year_in = YEAR_W'($urandom_range(0, 9999));
                endcase
                if ($urandom_range(0, 19) == 0)
                    date.month_in = MONTH_W'($urandom_range(12, 15));
                else
                    date.month_in = MONTH_W'($urandom_range(0, 11));
                // allow february 29 attempts in every year
                len = (date.month_in > 11) ? 31 :
                      month_days(int'(date.month_in)) + ((date.month_in == 1) ? 1 : 0);
                r = int'($urandom_range(0, 99));
                if (r < 3)
                    date.day_in = 0;
                else if (r < 8)
                    date.day_in = FIELD6_W'($urandom_range(29, 63));
                else
                    date.day_in = FIELD6_W'($urandom_range(1, len));
                date.hour_in = ($urandom_range(0, 19) == 0) ?
                               FIELD6_W'($urandom_range(24, 63)) :
                               FIELD6_W'($urandom_range(0, 23));
                date.minute_in = ($urandom_range(0, 19) == 0) ?
                                 FIELD6_W'($urandom_range(60, 63)) :
                                 FIELD6_W'($urandom_range(0, 59));
                date.second_in = ($urandom_range(0, 19) == 0) ?
                                 FIELD6_W'($urandom_range(60, 63)) :
                                 FIELD6_W'($urandom_range(0, 59));
                pending_dates.push_back(date);
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
